// ===== src/i2c_eeprom_master_defines.svh =====
// Assertion helpers included by the RTL.
`ifndef I2C_EEPROM_MASTER_DEFINES_SVH
`define I2C_EEPROM_MASTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/i2cem_pkg.sv =====
package i2cem_pkg;

    // Memory address width on the bus and number of address bytes sent
    localparam int ADDRESS_WIDTH = 8;
    localparam int ADDR_BYTES    = (ADDRESS_WIDTH + 7) / 8;

    // Byte sequence steps
    localparam logic [2:0] LAST_ADDR_STEP = 3'(ADDR_BYTES);
    localparam logic [2:0] DATA_STEP      = 3'(ADDR_BYTES + 1);

    // Stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // Command kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_WRITE_WAIT     = 1'b1;

    // Register reset values
    localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd80;
    localparam logic [15:0] WRITE_WAIT_RST     = 16'd1254;

    // Bus phase sequencer
    typedef enum logic [4:0] {
        PH_IDLE,
        PH_START_HI,
        PH_START_LO,
        PH_SEND_LO,
        PH_SEND_HI,
        PH_ACK_LO,
        PH_ACK_HI,
        PH_RS_LO,
        PH_RS_HI,
        PH_RS_FALL,
        PH_RECV_LO,
        PH_RECV_HI,
        PH_NACK_LO,
        PH_NACK_HI,
        PH_STOP_LO,
        PH_STOP_MID,
        PH_STOP_HI,
        PH_WAIT
    } t_phase;

    // Byte transmitted at a given step of the transaction
    function automatic logic [7:0] byte_for_step(
        input logic [2:0] step,
        input logic [6:0] dev,
        input logic [7:0] addr,
        input logic [7:0] data,
        input logic       is_read
    );
        logic [7:0] b;
        if (step == 3'd0) begin
            b = {dev, 1'b0};
        end else if (step <= LAST_ADDR_STEP) begin
            b = (step == LAST_ADDR_STEP) ? addr : 8'd0;
        end else if (is_read) begin
            b = {dev, 1'b1};
        end else begin
            b = data;
        end
        return b;
    endfunction

endpackage

// ===== src/i2c_eeprom_master.sv =====
// The result beat for an input beat is registered and appears on the master side in the cycle after it is accepted.
// Throughput: one beat per cycle while the master side is ready; the output register lets a new beat in while
// the previous result is taken in the same cycle.
// A write occupies the sequencer for its bus phases plus r_write_wait beats.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle, clears state,
// empties the output register and loads the register defaults (0x50, 1254).
`include "i2c_eeprom_master_defines.svh"

module i2c_eeprom_master (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] address, [15:8] write_data, [16] sda_in, [23:17] zero
    input  logic [i2cem_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]                         s_axis_tuser,
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] scl, [1] sda_release, [2] busy_res, [10:3] read_data, [15:11] zero
    output logic [i2cem_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] read_valid
    output logic                               m_axis_tuser,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);

    // Configuration registers
    logic [6:0]  r_device_address;
    logic [15:0] r_write_wait;

    // Sequencer state
    i2cem_pkg::t_phase r_phase, n_phase, w_phase;
    logic [2:0]  r_bit_count, n_bit_count;
    logic [2:0]  r_byte_step, n_byte_step;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_held_address, n_held_address;
    logic [7:0]  r_held_data, n_held_data;
    logic        r_is_read, n_is_read;
    logic [15:0] r_wait_count, n_wait_count;
    logic [7:0]  r_last_read, n_last_read;

    // Output register
    logic                             r_m_tvalid;
    logic [i2cem_pkg::OUT_TDATA_W-1:0] r_m_tdata;
    logic                             r_m_tuser;

    // Beat fields
    logic [1:0] w_kind;
    logic [7:0] w_address;
    logic [7:0] w_write_data;
    logic       w_sda;
    logic       w_accept;
    logic       w_cmd;
    logic [2:0] w_step_inc;
    logic [7:0] w_send_byte;

    // Per-tick line levels
    logic w_scl, w_rel, w_busy, w_valid;

    assign w_kind       = s_axis_tuser;
    assign w_address    = s_axis_tdata[7:0];
    assign w_write_data = s_axis_tdata[15:8];
    assign w_sda        = s_axis_tdata[16];

    assign s_axis_tready = !r_m_tvalid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // A new command is taken only from idle; its beat already runs START_HI
    assign w_cmd = (r_phase == i2cem_pkg::PH_IDLE) &&
                   ((w_kind == i2cem_pkg::KIND_WRITE) || (w_kind == i2cem_pkg::KIND_READ));
    assign w_phase = w_cmd ? i2cem_pkg::PH_START_HI : r_phase;

    // Byte to load when a send begins
    assign w_step_inc  = r_byte_step + 3'd1;
    assign w_send_byte = i2cem_pkg::byte_for_step(
        (w_phase == i2cem_pkg::PH_ACK_HI) ? w_step_inc :
        (w_phase == i2cem_pkg::PH_START_LO) ? 3'd0 : r_byte_step,
        r_device_address, r_held_address, r_held_data, r_is_read);

    // Next state
    always_comb begin
        n_phase        = w_phase;
        n_bit_count    = r_bit_count;
        n_byte_step    = r_byte_step;
        n_shift        = r_shift;
        n_held_address = r_held_address;
        n_held_data    = r_held_data;
        n_is_read      = r_is_read;
        n_wait_count   = r_wait_count;
        n_last_read    = r_last_read;

        if (w_cmd) begin
            n_held_address = w_address;
            n_held_data    = w_write_data;
            n_is_read      = (w_kind == i2cem_pkg::KIND_READ);
            n_byte_step    = 3'd0;
            n_bit_count    = 3'd0;
        end

        case (w_phase)
            i2cem_pkg::PH_START_HI: begin
                n_phase = i2cem_pkg::PH_START_LO;
            end
            i2cem_pkg::PH_START_LO: begin
                n_byte_step = 3'd0;
                n_shift     = w_send_byte;
                n_bit_count = 3'd0;
                n_phase     = i2cem_pkg::PH_SEND_LO;
            end
            i2cem_pkg::PH_SEND_LO: begin
                n_phase = i2cem_pkg::PH_SEND_HI;
            end
            i2cem_pkg::PH_SEND_HI: begin
                n_shift = {r_shift[6:0], 1'b0};
                if (r_bit_count == 3'd7) begin
                    n_bit_count = 3'd0;
                    n_phase     = i2cem_pkg::PH_ACK_LO;
                end else begin
                    n_bit_count = r_bit_count + 3'd1;
                    n_phase     = i2cem_pkg::PH_SEND_LO;
                end
            end
            i2cem_pkg::PH_ACK_LO: begin
                n_phase = i2cem_pkg::PH_ACK_HI;
            end
            i2cem_pkg::PH_ACK_HI: begin
                // hold until the slave pulls data low
                if (!w_sda) begin
                    n_byte_step = w_step_inc;
                    if ((w_step_inc <= i2cem_pkg::LAST_ADDR_STEP) ||
                        ((w_step_inc == i2cem_pkg::DATA_STEP) && !r_is_read)) begin
                        n_shift     = w_send_byte;
                        n_bit_count = 3'd0;
                        n_phase     = i2cem_pkg::PH_SEND_LO;
                    end else if (w_step_inc == i2cem_pkg::DATA_STEP) begin
                        n_phase = i2cem_pkg::PH_RS_LO;
                    end else if (r_is_read) begin
                        n_shift     = 8'd0;
                        n_bit_count = 3'd0;
                        n_phase     = i2cem_pkg::PH_RECV_LO;
                    end else begin
                        n_phase = i2cem_pkg::PH_STOP_LO;
                    end
                end
            end
            i2cem_pkg::PH_RS_LO: begin
                n_phase = i2cem_pkg::PH_RS_HI;
            end
            i2cem_pkg::PH_RS_HI: begin
                n_phase = i2cem_pkg::PH_RS_FALL;
            end
            i2cem_pkg::PH_RS_FALL: begin
                n_shift     = w_send_byte;
                n_bit_count = 3'd0;
                n_phase     = i2cem_pkg::PH_SEND_LO;
            end
            i2cem_pkg::PH_RECV_LO: begin
                n_phase = i2cem_pkg::PH_RECV_HI;
            end
            i2cem_pkg::PH_RECV_HI: begin
                n_shift = {r_shift[6:0], w_sda};
                if (r_bit_count == 3'd7) begin
                    n_bit_count = 3'd0;
                    n_phase     = i2cem_pkg::PH_NACK_LO;
                end else begin
                    n_bit_count = r_bit_count + 3'd1;
                    n_phase     = i2cem_pkg::PH_RECV_LO;
                end
            end
            i2cem_pkg::PH_NACK_LO: begin
                n_phase = i2cem_pkg::PH_NACK_HI;
            end
            i2cem_pkg::PH_NACK_HI: begin
                n_phase = i2cem_pkg::PH_STOP_LO;
            end
            i2cem_pkg::PH_STOP_LO: begin
                n_phase = i2cem_pkg::PH_STOP_MID;
            end
            i2cem_pkg::PH_STOP_MID: begin
                n_phase = i2cem_pkg::PH_STOP_HI;
            end
            i2cem_pkg::PH_STOP_HI: begin
                if (r_is_read) begin
                    n_last_read = r_shift;
                    n_phase     = i2cem_pkg::PH_IDLE;
                end else if (r_write_wait != 16'd0) begin
                    n_wait_count = r_write_wait;
                    n_phase      = i2cem_pkg::PH_WAIT;
                end else begin
                    n_phase = i2cem_pkg::PH_IDLE;
                end
            end
            i2cem_pkg::PH_WAIT: begin
                n_wait_count = r_wait_count - 16'd1;
                if (r_wait_count == 16'd1) begin
                    n_phase = i2cem_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = i2cem_pkg::PH_IDLE;
            end
        endcase
    end

    // Line levels and flags for this tick
    always_comb begin
        w_scl   = 1'b1;
        w_rel   = 1'b1;
        w_busy  = 1'b1;
        w_valid = 1'b0;
        case (w_phase)
            i2cem_pkg::PH_START_HI: begin
            end
            i2cem_pkg::PH_START_LO: begin
                w_rel = 1'b0;
            end
            i2cem_pkg::PH_SEND_LO: begin
                w_scl = 1'b0;
                w_rel = r_shift[7];
            end
            i2cem_pkg::PH_SEND_HI: begin
                w_rel = r_shift[7];
            end
            i2cem_pkg::PH_ACK_LO,
            i2cem_pkg::PH_RS_LO,
            i2cem_pkg::PH_RECV_LO,
            i2cem_pkg::PH_NACK_LO: begin
                w_scl = 1'b0;
            end
            i2cem_pkg::PH_ACK_HI,
            i2cem_pkg::PH_RS_HI,
            i2cem_pkg::PH_RECV_HI,
            i2cem_pkg::PH_NACK_HI,
            i2cem_pkg::PH_WAIT: begin
            end
            i2cem_pkg::PH_RS_FALL,
            i2cem_pkg::PH_STOP_MID: begin
                w_rel = 1'b0;
            end
            i2cem_pkg::PH_STOP_LO: begin
                w_scl = 1'b0;
                w_rel = 1'b0;
            end
            i2cem_pkg::PH_STOP_HI: begin
                w_valid = r_is_read;
            end
            default: begin
                w_busy = 1'b0;
            end
        endcase
    end

    // Sequencer registers advance once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= i2cem_pkg::PH_IDLE;
            r_bit_count    <= 3'd0;
            r_byte_step    <= 3'd0;
            r_shift        <= 8'd0;
            r_held_address <= 8'd0;
            r_held_data    <= 8'd0;
            r_is_read      <= 1'b0;
            r_wait_count   <= 16'd0;
            r_last_read    <= 8'd0;
        end else if (w_accept) begin
            r_phase        <= n_phase;
            r_bit_count    <= n_bit_count;
            r_byte_step    <= n_byte_step;
            r_shift        <= n_shift;
            r_held_address <= n_held_address;
            r_held_data    <= n_held_data;
            r_is_read      <= n_is_read;
            r_wait_count   <= n_wait_count;
            r_last_read    <= n_last_read;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= i2cem_pkg::DEVICE_ADDRESS_RST;
            r_write_wait     <= i2cem_pkg::WRITE_WAIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == i2cem_pkg::CFG_DEVICE_ADDRESS) begin
                r_device_address <= i_cfg_data[6:0];
            end else if (i_cfg_index == i2cem_pkg::CFG_WRITE_WAIT) begin
                r_write_wait <= i_cfg_data;
            end
        end
    end

    // Output register: loads whenever the slave side may take a beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (s_axis_tready) begin
            r_m_tvalid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_tdata <= {5'd0, n_last_read, w_busy, w_rel, w_scl};
            r_m_tuser <= w_valid;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // Write wait is entered only with a nonzero count and left when it runs out
    `ASSERT_IMPLIES(a_wait_nonzero, i_clk, i_rst_n,
        r_phase == i2cem_pkg::PH_WAIT, r_wait_count != 16'd0)

    // A write command from idle moves straight to the low half of START
    `ASSERT_NEXT(a_write_start, i_clk, i_rst_n,
        w_accept && (r_phase == i2cem_pkg::PH_IDLE) &&
        (s_axis_tuser == i2cem_pkg::KIND_WRITE),
        (r_phase == i2cem_pkg::PH_START_LO) && !r_is_read)

    // A pending read-complete beat means the sequencer is back in idle
    `ASSERT_IMPLIES(a_read_done_idle, i_clk, i_rst_n,
        r_m_tvalid && r_m_tuser,
        (r_phase == i2cem_pkg::PH_IDLE) && (r_m_tdata[10:3] == r_last_read))

endmodule
